/* hw/rtl/i2cm_pkg.sv */
// Shared types and codes for the I2C master byte engine.
`timescale 1ns / 1ps

package i2cm_pkg;

  // Command codes
  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_STOP  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_WAIT  = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;
  localparam logic [2:0] CMD_ACK   = 3'd5;
  localparam logic [2:0] CMD_NACK  = 3'd6;
  localparam logic [2:0] CMD_NONE  = 3'd7;

  // Configuration register indexes
  localparam logic [1:0] REG_PHASE_TICKS    = 2'd0;
  localparam logic [1:0] REG_ACK_POLL_LIMIT = 2'd1;
  localparam logic [1:0] REG_ACK_POLL_TICKS = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] PHASE_TICKS_RST    = 16'd30;
  localparam logic [7:0]  ACK_POLL_LIMIT_RST = 8'd250;
  localparam logic [15:0] ACK_POLL_TICKS_RST = 16'd300;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       sda_in;
  } in_word_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       no_ack;
  } out_word_t;

endpackage

/* hw/rtl/i2c_master_byte_engine.sv */
// I2C master byte engine: bit-level SCL/SDA sequencer advanced once per input word.
`timescale 1ns / 1ps

// Each input word is one bus tick; it may carry a command (start, stop, write byte,
// wait for acknowledge, read byte, ack, nack) and always carries the sampled SDA
// level. The engine takes one word per clock cycle unless the input is stalled and
// returns one result word per input word, showing the SCL/SDA drive, busy, done,
// the last read byte and the no-acknowledge flag after that tick. The tick update is
// a single pass of logic from the state registers into the result register; the
// result register decouples the two channels, so input is stalled only while a
// result waits and the output is stalled. Phase lengths and the acknowledge poll
// limit come from the configuration registers, which should only be written while idle.
module i2c_master_byte_engine (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  i2cm_pkg::in_word_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output i2cm_pkg::out_word_t                  out_data,
  input  logic                                 cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import i2cm_pkg::*;

  logic [15:0] phase_ticks_r;
  logic [7:0]  ack_poll_limit_r;
  logic [15:0] ack_poll_ticks_r;

  logic [2:0]  act_r, act_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [7:0]  poll_r, poll_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        drv_r, drv_nxt;
  logic        busy_r, busy_nxt;
  logic        noack_r, noack_nxt;
  logic [7:0]  rx_r, rx_nxt;
  logic        done_nxt;

  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_r;
  logic        in_accept;

  logic [15:0] len;
  logic        do_enter;
  logic [2:0]  enter_p;
  logic        fin;
  logic        ack_chk;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    act_nxt   = act_r;
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    tick_nxt  = tick_r;
    poll_nxt  = poll_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    drv_nxt   = drv_r;
    busy_nxt  = busy_r;
    noack_nxt = noack_r;
    rx_nxt    = rx_r;
    done_nxt  = 1'b0;
    do_enter  = 1'b0;
    enter_p   = 3'd0;
    fin       = 1'b0;
    ack_chk   = 1'b0;
    len       = (act_r == CMD_WAIT && phase_r == 3'd1) ? ack_poll_ticks_r : phase_ticks_r;

    if (busy_r) begin
      if (tick_r >= len) begin
        case (act_r)
          CMD_START, CMD_STOP: begin
            if (phase_r < 3'd2) begin
              do_enter = 1'b1;
              enter_p  = 3'(phase_r + 3'd1);
            end else begin
              fin = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (phase_r < 3'd3) begin
              do_enter = 1'b1;
              enter_p  = 3'(phase_r + 3'd1);
            end else if (phase_r == 3'd3) begin
              bit_nxt  = 4'(bit_r + 4'd1);
              do_enter = 1'b1;
              enter_p  = (bit_nxt < 4'd8) ? 3'd1 : 3'd4;
            end else begin
              fin = 1'b1;
            end
          end
          CMD_WAIT: begin
            if (phase_r == 3'd0) begin
              poll_nxt = 8'd0;
              ack_chk  = 1'b1;
            end else if (poll_r >= ack_poll_limit_r) begin
              noack_nxt = 1'b1;
              fin       = 1'b1;
            end else begin
              poll_nxt = 8'(poll_r + 8'd1);
              ack_chk  = 1'b1;
            end
          end
          CMD_READ: begin
            if (phase_r == 3'd0) begin
              do_enter = 1'b1;
              enter_p  = 3'd1;
            end else if (phase_r == 3'd1) begin
              // sample on the last tick of SCL high
              shift_nxt = {shift_r[6:0], in_data.sda_in};
              do_enter  = 1'b1;
              enter_p   = 3'd2;
            end else begin
              bit_nxt = 4'(bit_r + 4'd1);
              if (bit_nxt < 4'd8) begin
                do_enter = 1'b1;
                enter_p  = 3'd1;
              end else begin
                rx_nxt = shift_r;
                fin    = 1'b1;
              end
            end
          end
          CMD_ACK, CMD_NACK: begin
            if (phase_r < 3'd3) begin
              do_enter = 1'b1;
              enter_p  = 3'(phase_r + 3'd1);
            end else begin
              fin = 1'b1;
            end
          end
          default: fin = 1'b1;
        endcase

        if (ack_chk) begin
          if (!in_data.sda_in) begin
            scl_nxt   = 1'b0;
            noack_nxt = 1'b0;
            fin       = 1'b1;
          end else begin
            do_enter = 1'b1;
            enter_p  = 3'd1;
          end
        end
      end else begin
        tick_nxt = 16'(tick_r + 16'd1);
      end
    end else if (in_data.cmd_valid && in_data.command != CMD_NONE) begin
      act_nxt  = in_data.command;
      busy_nxt = 1'b1;
      bit_nxt  = 4'd0;
      poll_nxt = 8'd0;
      if (in_data.command == CMD_WRITE) begin
        shift_nxt = in_data.tx_byte;
      end else if (in_data.command == CMD_READ) begin
        shift_nxt = 8'd0;
      end
      do_enter = 1'b1;
      enter_p  = 3'd0;
    end

    // line settings on entry to a phase
    if (do_enter) begin
      phase_nxt = enter_p;
      tick_nxt  = 16'd1;
      case (act_nxt)
        CMD_START: begin
          if (enter_p == 3'd0) begin
            scl_nxt = 1'b1;
            sda_nxt = 1'b1;
            drv_nxt = 1'b1;
          end else if (enter_p == 3'd1) begin
            sda_nxt = 1'b0;
          end else begin
            scl_nxt = 1'b0;
          end
        end
        CMD_STOP: begin
          if (enter_p == 3'd0) begin
            drv_nxt = 1'b1;
            sda_nxt = 1'b0;
          end else if (enter_p == 3'd1) begin
            scl_nxt = 1'b1;
          end else begin
            sda_nxt = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (enter_p == 3'd0) begin
            drv_nxt = 1'b1;
            scl_nxt = 1'b0;
          end else if (enter_p == 3'd1) begin
            sda_nxt   = shift_nxt[7];
            shift_nxt = {shift_nxt[6:0], 1'b0};
          end else if (enter_p == 3'd2) begin
            scl_nxt = 1'b1;
          end else if (enter_p == 3'd3) begin
            scl_nxt = 1'b0;
          end else begin
            sda_nxt = 1'b1;
          end
        end
        CMD_WAIT: begin
          if (enter_p == 3'd0) begin
            drv_nxt = 1'b0;
            scl_nxt = 1'b1;
          end
        end
        CMD_READ: begin
          if (enter_p == 3'd0) begin
            drv_nxt = 1'b0;
          end else if (enter_p == 3'd1) begin
            scl_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b0;
          end
        end
        default: begin
          if (enter_p == 3'd0) begin
            scl_nxt = 1'b0;
          end else if (enter_p == 3'd1) begin
            drv_nxt = 1'b1;
            sda_nxt = (act_nxt == CMD_NACK);
          end else if (enter_p == 3'd2) begin
            scl_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b0;
          end
        end
      endcase
    end

    if (fin) begin
      busy_nxt  = 1'b0;
      done_nxt  = 1'b1;
      phase_nxt = 3'd0;
      tick_nxt  = 16'd0;
    end
  end

  always_comb begin
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r    <= PHASE_TICKS_RST;
      ack_poll_limit_r <= ACK_POLL_LIMIT_RST;
      ack_poll_ticks_r <= ACK_POLL_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PHASE_TICKS:    phase_ticks_r    <= cfg_wdata;
        REG_ACK_POLL_LIMIT: ack_poll_limit_r <= cfg_wdata[7:0];
        REG_ACK_POLL_TICKS: ack_poll_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= CMD_START;
      phase_r     <= 3'd0;
      bit_r       <= 4'd0;
      shift_r     <= 8'd0;
      tick_r      <= 16'd0;
      poll_r      <= 8'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      drv_r       <= 1'b1;
      busy_r      <= 1'b0;
      noack_r     <= 1'b0;
      rx_r        <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_accept) begin
        act_r   <= act_nxt;
        phase_r <= phase_nxt;
        bit_r   <= bit_nxt;
        shift_r <= shift_nxt;
        tick_r  <= tick_nxt;
        poll_r  <= poll_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        drv_r   <= drv_nxt;
        busy_r  <= busy_nxt;
        noack_r <= noack_nxt;
        rx_r    <= rx_nxt;
      end
    end
  end

  // result word register, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_r.scl_level <= scl_nxt;
      out_r.sda_level <= sda_nxt;
      out_r.sda_drive <= drv_nxt;
      out_r.busy_res  <= busy_nxt;
      out_r.done_res  <= done_nxt;
      out_r.rx_byte   <= rx_nxt;
      out_r.no_ack    <= noack_nxt;
    end
  end

  // idle engine always sits at phase zero with the tick counter cleared
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (phase_r == 3'd0 && tick_r == 16'd0))
    else $error("idle engine with stale phase or tick count");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r <= 3'd4) && (bit_r <= 4'd8))
    else $error("phase or bit index out of range");

  a_done_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && done_nxt) |-> busy_r)
    else $error("done raised without a command in progress");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.done_res && out_r.busy_res))
    else $error("result word shows done and busy together");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && !in_accept) |=> (out_valid_r && $stable(out_r)))
    else $error("held result word lost or changed");

endmodule

/* tb/sv/tb_i2c_master_byte_engine.sv */
// Testbench for the I2C master byte engine: bus-tick stream driver, line-state predictor, monitor.
`timescale 1ns / 1ps

module tb_i2c_master_byte_engine;
  import i2cm_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  i2c_master_byte_engine i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Engine copy: configuration and state
  logic [15:0] cfg_phase = PHASE_TICKS_RST;
  logic [7:0]  cfg_poll_limit = ACK_POLL_LIMIT_RST;
  logic [15:0] cfg_poll_ticks = ACK_POLL_TICKS_RST;
  logic [2:0]  eng_cmd = '0;
  logic [2:0]  eng_phase = '0;
  logic [3:0]  eng_bit = '0;
  logic [7:0]  eng_shift = '0;
  logic [15:0] eng_ticks = '0;
  logic [7:0]  eng_polls = '0;
  logic        eng_scl = 1'b1;
  logic        eng_sda = 1'b1;
  logic        eng_drive = 1'b1;
  logic        eng_busy = 1'b0;
  logic        eng_nack = 1'b0;
  logic        eng_done = 1'b0;
  logic [7:0]  eng_rx = '0;

  in_word_t  tick_words_q[$];
  out_word_t want_lines_q[$];

  int err_cnt = 0;
  int ticks_fed = 0;
  int lines_checked = 0;
  int cmds_started = 0;
  int timeouts_seen = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  bit idle_on = 1'b1;

  function automatic void set_phase_lines(input logic [2:0] p);
    eng_phase = p;
    eng_ticks = 16'd1;
    case (eng_cmd)
      CMD_START: begin
        if (p == 3'd0) begin
          eng_scl = 1'b1; eng_sda = 1'b1; eng_drive = 1'b1;
        end else if (p == 3'd1) eng_sda = 1'b0;
        else eng_scl = 1'b0;
      end
      CMD_STOP: begin
        if (p == 3'd0) begin
          eng_drive = 1'b1; eng_sda = 1'b0;
        end else if (p == 3'd1) eng_scl = 1'b1;
        else eng_sda = 1'b1;
      end
      CMD_WRITE: begin
        if (p == 3'd0) begin
          eng_drive = 1'b1; eng_scl = 1'b0;
        end else if (p == 3'd1) begin
          eng_sda = eng_shift[7];
          eng_shift = {eng_shift[6:0], 1'b0};
        end else if (p == 3'd2) eng_scl = 1'b1;
        else if (p == 3'd3) eng_scl = 1'b0;
        else eng_sda = 1'b1;
      end
      CMD_WAIT: begin
        if (p == 3'd0) begin
          eng_drive = 1'b0; eng_scl = 1'b1;
        end
      end
      CMD_READ: begin
        if (p == 3'd0) eng_drive = 1'b0;
        else if (p == 3'd1) eng_scl = 1'b1;
        else eng_scl = 1'b0;
      end
      default: begin
        if (p == 3'd0) eng_scl = 1'b0;
        else if (p == 3'd1) begin
          eng_drive = 1'b1;
          eng_sda = (eng_cmd == CMD_NACK);
        end else if (p == 3'd2) eng_scl = 1'b1;
        else eng_scl = 1'b0;
      end
    endcase
  endfunction

  function automatic void end_command();
    eng_busy = 1'b0;
    eng_done = 1'b1;
    eng_phase = '0;
    eng_ticks = '0;
  endfunction

  function automatic void sample_ack(input logic sda);
    if (!sda) begin
      eng_scl = 1'b0;
      eng_nack = 1'b0;
      end_command();
    end else begin
      set_phase_lines(3'd1);
    end
  endfunction

  function automatic void next_phase(input logic sda);
    case (eng_cmd)
      CMD_START, CMD_STOP: begin
        if (eng_phase < 3'd2) set_phase_lines(eng_phase + 3'd1);
        else end_command();
      end
      CMD_WRITE: begin
        if (eng_phase < 3'd3) set_phase_lines(eng_phase + 3'd1);
        else if (eng_phase == 3'd3) begin
          eng_bit = eng_bit + 4'd1;
          if (eng_bit < 4'd8) set_phase_lines(3'd1);
          else set_phase_lines(3'd4);
        end else end_command();
      end
      CMD_WAIT: begin
        if (eng_phase == 3'd0) begin
          eng_polls = '0;
          sample_ack(sda);
        end else if (eng_polls >= cfg_poll_limit) begin
          eng_nack = 1'b1;
          timeouts_seen++;
          end_command();
        end else begin
          eng_polls = eng_polls + 8'd1;
          sample_ack(sda);
        end
      end
      CMD_READ: begin
        if (eng_phase == 3'd0) set_phase_lines(3'd1);
        else if (eng_phase == 3'd1) begin
          eng_shift = {eng_shift[6:0], sda};
          set_phase_lines(3'd2);
        end else begin
          eng_bit = eng_bit + 4'd1;
          if (eng_bit < 4'd8) set_phase_lines(3'd1);
          else begin
            eng_rx = eng_shift;
            end_command();
          end
        end
      end
      CMD_ACK, CMD_NACK: begin
        if (eng_phase < 3'd3) set_phase_lines(eng_phase + 3'd1);
        else end_command();
      end
      default: end_command();
    endcase
  endfunction

  // One bus tick: returns the line state after this tick
  function automatic out_word_t bus_tick(input in_word_t w);
    out_word_t r;
    logic [15:0] len;
    eng_done = 1'b0;
    if (eng_busy) begin
      len = (eng_cmd == CMD_WAIT && eng_phase == 3'd1) ? cfg_poll_ticks : cfg_phase;
      if (eng_ticks >= len) next_phase(w.sda_in);
      else eng_ticks = eng_ticks + 16'd1;
    end else if (w.cmd_valid && w.command != CMD_NONE) begin
      eng_cmd = w.command;
      eng_busy = 1'b1;
      eng_bit = '0;
      eng_polls = '0;
      cmds_started++;
      if (w.command == CMD_WRITE) eng_shift = w.tx_byte;
      else if (w.command == CMD_READ) eng_shift = '0;
      set_phase_lines(3'd0);
    end
    r.scl_level = eng_scl;
    r.sda_level = eng_sda;
    r.sda_drive = eng_drive;
    r.busy_res  = eng_busy;
    r.done_res  = eng_done;
    r.rx_byte   = eng_rx;
    r.no_ack    = eng_nack;
    return r;
  endfunction

  // Mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 97) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR line state %0d: %s", lines_checked, msg);
    err_cnt++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // Driver: one word per tick from the pending queue
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want_lines_q.push_back(bus_tick(in_data));
        ticks_fed++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (tick_words_q.size() > 0) begin
          in_data <= tick_words_q.pop_front();
          in_valid <= 1'b1;
          gap_left <= idle_on ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted word with the oldest expected line state
  always @(posedge clk) begin
    int n;
    out_word_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (want_lines_q.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = want_lines_q.pop_front();
          check_field("scl_level", out_data.scl_level, want.scl_level);
          check_field("sda_level", out_data.sda_level, want.sda_level);
          check_field("sda_drive", out_data.sda_drive, want.sda_drive);
          check_field("busy_res", out_data.busy_res, want.busy_res);
          check_field("done_res", out_data.done_res, want.done_res);
          check_field("rx_byte", out_data.rx_byte, want.rx_byte);
          check_field("no_ack", out_data.no_ack, want.no_ack);
        end
        lines_checked++;
      end
      if (hold_seen != hold_asks) begin
        hold_seen <= hold_asks;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        n = idle_on ? pick_gap() : 0;
        stall_left <= (n > 0) ? n - 1 : 0;
        out_stall <= (n > 0);
      end
    end
  end

  initial begin
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("timeout after %0d cycles", cycles);
    $display("tb_i2c_master_byte_engine NOT OK");
    $finish;
  end

  function automatic int cmd_len(input logic [2:0] cmd, input int polls);
    int p;
    int q;
    p = (cfg_phase == 16'd0) ? 1 : int'(cfg_phase);
    q = (cfg_poll_ticks == 16'd0) ? 1 : int'(cfg_poll_ticks);
    case (cmd)
      CMD_START, CMD_STOP: return 3 * p;
      CMD_WRITE:           return 26 * p;
      CMD_READ:            return 17 * p;
      CMD_ACK, CMD_NACK:   return 4 * p;
      CMD_WAIT:            return p + polls * q;
      default:             return 0;
    endcase
  endfunction

  // Command word followed by fill ticks; sda high before low_from, low from there on
  task automatic push_cmd(input logic [2:0] cmd, input logic [7:0] tx, input int fill,
                          input int low_from, input bit noisy);
    in_word_t w;
    int i;
    w.cmd_valid = 1'b1;
    w.command = cmd;
    w.tx_byte = tx;
    w.sda_in = 1'($urandom);
    tick_words_q.push_back(w);
    for (i = 0; i < fill; i++) begin
      w.cmd_valid = noisy && ($urandom_range(0, 15) == 0);
      w.command = 3'($urandom);
      w.tx_byte = 8'($urandom);
      w.sda_in = (low_from < 0) ? 1'($urandom) : (i < low_from);
      tick_words_q.push_back(w);
    end
  endtask

  // polls < 0 on a wait: slave never acknowledges
  task automatic issue(input logic [2:0] cmd, input logic [7:0] tx, input int polls,
                       input int extra, input bit noisy);
    int fill;
    int low;
    low = -1;
    if (cmd == CMD_WAIT) begin
      if (polls < 0) begin
        fill = cmd_len(CMD_WAIT, int'(cfg_poll_limit) + 1);
        low = fill + extra + 1;
      end else begin
        fill = cmd_len(CMD_WAIT, polls);
        low = fill - 1;
      end
    end else begin
      fill = cmd_len(cmd, 0);
    end
    push_cmd(cmd, tx, fill + extra, low, noisy);
  endtask

  // Wait for every word to be accepted and checked, then run the engine idle
  task automatic settle();
    in_word_t w;
    do begin
      while (tick_words_q.size() != 0 || in_valid || want_lines_q.size() != 0)
        @(negedge clk);
      if (eng_busy) begin
        repeat (16) begin
          w = '0;
          w.sda_in = 1'($urandom);
          tick_words_q.push_back(w);
        end
      end
    end while (eng_busy || tick_words_q.size() != 0);
  endtask

  task automatic write_regs(input logic [15:0] pt, input logic [7:0] pl, input logic [15:0] pp);
    logic [7:0] hi;
    hi = 8'($urandom);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_PHASE_TICKS;
    cfg_wdata <= pt;
    @(posedge clk);
    cfg_index <= REG_ACK_POLL_LIMIT;
    cfg_wdata <= {hi, pl};
    @(posedge clk);
    cfg_index <= REG_ACK_POLL_TICKS;
    cfg_wdata <= pp;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_phase = pt;
    cfg_poll_limit = pl;
    cfg_poll_ticks = pp;
    @(negedge clk);
  endtask

  // Mostly complete commands with random content, some cut short or invalid
  task automatic random_traffic(input int n_ticks);
    int start_len;
    int polls;
    int extra;
    int r;
    int q;
    logic [2:0] cmd;
    start_len = tick_words_q.size();
    q = (cfg_poll_ticks == 16'd0) ? 1 : int'(cfg_poll_ticks);
    while (tick_words_q.size() - start_len < n_ticks) begin
      cmd = 3'($urandom_range(CMD_START, CMD_NACK));
      r = $urandom_range(0, 99);
      if (r < 85) begin
        polls = $urandom_range(0, (cfg_poll_limit < 4) ? cfg_poll_limit : 4);
        if ((int'(cfg_poll_limit) + 1) * q <= 64 && $urandom_range(0, 4) == 0) polls = -1;
        r = $urandom_range(0, 99);
        if (r < 60) extra = 0;
        else if (r < 80) extra = $urandom_range(1, 3);
        else if (r < 90) extra = -1;
        else extra = -$urandom_range(2, 4);
        issue(cmd, 8'($urandom), polls, extra, 1'b1);
      end else if (r < 92) begin
        push_cmd(CMD_NONE, 8'($urandom), $urandom_range(0, 4), -1, 1'b0);
      end else begin
        push_cmd(cmd, 8'($urandom), $urandom_range(0, cmd_len(cmd, 1) / 2), -1, 1'b1);
      end
    end
  endtask

  initial begin
    int waited;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset value of the phase length
    issue(CMD_START, 8'h00, 0, 0, 1'b0);
    issue(CMD_STOP, 8'h00, 0, 2, 1'b0);
    settle();

    write_regs(16'd1, 8'd2, 16'd1);
    issue(CMD_START, 8'h00, 0, 0, 1'b0);
    issue(CMD_WRITE, 8'h00, 0, 0, 1'b0);
    issue(CMD_WAIT, 8'h00, 0, 0, 1'b0);
    issue(CMD_WRITE, 8'hFF, 0, 0, 1'b0);
    issue(CMD_WAIT, 8'h00, 2, 0, 1'b0);
    issue(CMD_WAIT, 8'h00, -1, 2, 1'b0);
    issue(CMD_READ, 8'h00, 0, 0, 1'b0);
    issue(CMD_ACK, 8'h00, 0, 0, 1'b0);
    issue(CMD_READ, 8'h00, 0, 1, 1'b0);
    issue(CMD_NACK, 8'h00, 0, 0, 1'b0);
    // next command lands on the finishing tick, then one mid-command
    issue(CMD_START, 8'h00, 0, -1, 1'b0);
    issue(CMD_STOP, 8'h00, 0, 0, 1'b0);
    issue(CMD_WRITE, 8'h3C, 0, -5, 1'b0);
    issue(CMD_READ, 8'h00, 0, 0, 1'b0);
    push_cmd(CMD_NONE, 8'hFF, 3, -1, 1'b0);
    issue(CMD_STOP, 8'h00, 0, 0, 1'b0);
    settle();

    // Zero lengths act as one tick, zero poll limit times out after one gap
    write_regs(16'd0, 8'd0, 16'd0);
    issue(CMD_START, 8'h00, 0, 0, 1'b0);
    issue(CMD_WAIT, 8'h00, -1, 0, 1'b0);
    issue(CMD_WAIT, 8'h00, 0, 0, 1'b0);
    issue(CMD_WRITE, 8'($urandom), 0, 0, 1'b0);
    issue(CMD_READ, 8'h00, 0, 0, 1'b0);
    issue(CMD_STOP, 8'h00, 0, 0, 1'b0);
    settle();

    // Poll limit reached exactly, back to back
    idle_on = 1'b0;
    write_regs(16'd1, 8'd20, 16'd1);
    issue(CMD_WAIT, 8'h00, -1, 0, 1'b0);
    issue(CMD_WAIT, 8'h00, 20, 0, 1'b0);
    settle();
    idle_on = 1'b1;

    write_regs(16'd1, 8'd3, 16'd2);
    random_traffic(30);
    hold_asks++;
    settle();

    write_regs(16'd2, 8'd1, 16'd3);
    random_traffic(30);
    settle();

    write_regs(16'($urandom_range(1, 3)), 8'($urandom_range(0, 5)),
               16'($urandom_range(1, 4)));
    random_traffic(20);
    settle();

    waited = 0;
    while (want_lines_q.size() != 0 && waited < 1000) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(negedge clk);
    if (want_lines_q.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", want_lines_q.size()));

    $display("ran %0d bus ticks, %0d commands started, %0d acknowledge timeouts",
             ticks_fed, cmds_started, timeouts_seen);
    $display("checked %0d result words over seven register settings, %0d errors",
             lines_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_i2c_master_byte_engine OK");
    end else begin
      $display("tb_i2c_master_byte_engine NOT OK");
    end
    $finish;
  end

endmodule
